// ===== rtl/core/qecs_pkg.sv =====
// Shared types, constants and helpers for the quadrature edge counter.
package qecs_pkg;

    localparam int NUM_CHANNELS_DEF = 2;
    localparam int CNT_W            = 32;
    localparam int OUT_W            = 16;
    localparam int READ_SPAN        = 2;

    localparam logic signed [CNT_W-1:0] SAT_MAX = 32'sd32767;
    localparam logic signed [CNT_W-1:0] SAT_MIN = -32'sd32768;

    typedef logic [CNT_W-1:0] count_t;
    typedef logic signed [OUT_W-1:0] result_t;

    typedef struct packed {
        logic step;
        logic snap;
    } lane_ctrl_t;

    function automatic result_t sat16(input count_t value);
        logic signed [CNT_W-1:0] sv;
        result_t res;
        sv = signed'(value);
        if (sv > SAT_MAX) begin
            res = SAT_MAX[OUT_W-1:0];
        end else if (sv < SAT_MIN) begin
            res = SAT_MIN[OUT_W-1:0];
        end else begin
            res = sv[OUT_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/qecs_lane.sv =====
// One channel lane: edge detect, raw and stable counters.
module qecs_lane (
    input  logic                aclk,
    input  logic                aresetn,
    input  qecs_pkg::lane_ctrl_t ctrl,
    input  logic                enable,
    input  logic                clear,
    input  logic                phase_a,
    input  logic                phase_b,
    output qecs_pkg::count_t    stable_next
);
    import qecs_pkg::*;

    logic   prev_a_reg;
    logic   prev_b_reg;
    count_t raw_reg;
    count_t raw_next;
    count_t stable_reg;
    count_t raw_adj;
    logic   active;

    always_comb begin
        logic signed [2:0] delta;
        logic rise_a;
        logic rise_b;
        rise_a = phase_a & ~prev_a_reg;
        rise_b = phase_b & ~prev_b_reg;
        delta  = 3'sd0;
        if (rise_a) begin
            delta = phase_b ? delta + 3'sd1 : delta - 3'sd1;
        end
        if (rise_b) begin
            delta = phase_a ? delta - 3'sd1 : delta + 3'sd1;
        end
        raw_adj = raw_reg + {{(CNT_W-3){delta[2]}}, delta};
    end

    assign active = ctrl.step & enable;

    always_comb begin
        raw_next    = raw_reg;
        stable_next = stable_reg;
        if (clear) begin
            raw_next    = '0;
            stable_next = '0;
        end else if (active) begin
            if (ctrl.snap) begin
                raw_next    = '0;
                stable_next = raw_adj;
            end else begin
                raw_next = raw_adj;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_a_reg <= 1'b1;
            prev_b_reg <= 1'b1;
            raw_reg    <= '0;
            stable_reg <= '0;
        end else begin
            raw_reg    <= raw_next;
            stable_reg <= stable_next;
            if (ctrl.step) begin
                prev_a_reg <= phase_a;
                prev_b_reg <= phase_b;
            end
        end
    end

endmodule

// ===== rtl/core/qecs_merge.sv =====
// Channel select, saturation and output register with skid stage.
module qecs_merge #(
    parameter int NumChannels = qecs_pkg::NUM_CHANNELS_DEF
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic [NumChannels-1:0][qecs_pkg::CNT_W-1:0] lane_stable,
    input  logic                                     read_channel,
    input  logic                                     accept,
    output logic                                     in_ready,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output qecs_pkg::result_t                        out_value
);
    import qecs_pkg::*;

    count_t  cand [READ_SPAN];
    result_t new_value;
    logic    out_valid_reg;
    result_t out_value_reg;
    logic    skid_valid_reg;
    result_t skid_value_reg;
    logic    pop;

    for (genvar g = 0; g < READ_SPAN; g++) begin : g_cand
        if (g < NumChannels) begin : g_live
            assign cand[g] = lane_stable[g];
        end else begin : g_none
            assign cand[g] = '0;
        end
    end

    assign new_value = sat16(cand[read_channel]);
    assign pop       = out_valid_reg & out_ready;
    assign in_ready  = ~skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_value_reg  <= skid_value_reg;
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_value_reg <= new_value;
                out_valid_reg <= accept;
            end
        end else if (accept) begin
            skid_value_reg <= new_value;
            skid_valid_reg <= 1'b1;
        end
    end

endmodule

// ===== rtl/core/quadrature_edge_counter_snapshot.sv =====
// Top level: multi-channel quadrature edge counter with snapshot readback.
// One pin sample per clock is accepted while s_ready is high; each transaction
// updates every enabled channel lane in the cycle it is taken and yields one
// registered result. Sustained rate is one transaction per cycle while m_ready
// keeps up; the longest path is a lane's 32-bit counter add feeding the channel
// select and 16-bit saturation. A two-entry output register plus skid stage
// absorbs a stalled m_ready; s_ready drops only while both entries are full.
// Writing cfg_enable_mask clears the counters of each newly enabled channel;
// disabling a channel freezes its counters, which remain readable.
module quadrature_edge_counter_snapshot #(
    parameter int NUM_CHANNELS = qecs_pkg::NUM_CHANNELS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [NUM_CHANNELS-1:0] cfg_enable_mask,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [NUM_CHANNELS-1:0] s_phase_a_levels,
    input  logic [NUM_CHANNELS-1:0] s_phase_b_levels,
    input  logic                    s_snapshot,
    input  logic                    s_read_channel,
    output logic                    m_valid,
    input  logic                    m_ready,
    output qecs_pkg::result_t       m_count_value
);
    import qecs_pkg::*;

    logic [NUM_CHANNELS-1:0]            enable_reg;
    logic [NUM_CHANNELS-1:0]            enable_next;
    logic [NUM_CHANNELS-1:0]            lane_clear;
    logic [NUM_CHANNELS-1:0][CNT_W-1:0] lane_stable;
    logic                               cfg_write;
    logic                               accept;
    lane_ctrl_t                         ctrl;

    assign cfg_ready   = 1'b1;
    assign cfg_write   = cfg_valid & cfg_ready;
    assign enable_next = cfg_write ? cfg_enable_mask : enable_reg;
    assign lane_clear  = cfg_write ? (cfg_enable_mask & ~enable_reg) : '0;
    assign accept      = s_valid & s_ready;
    assign ctrl.step   = accept;
    assign ctrl.snap   = s_snapshot;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= '0;
        end else begin
            enable_reg <= enable_next;
        end
    end

    for (genvar ch = 0; ch < NUM_CHANNELS; ch++) begin : g_lane
        qecs_lane u_lane (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .enable      (enable_reg[ch]),
            .clear       (lane_clear[ch]),
            .phase_a     (s_phase_a_levels[ch]),
            .phase_b     (s_phase_b_levels[ch]),
            .stable_next (lane_stable[ch])
        );
    end

    qecs_merge #(
        .NumChannels (NUM_CHANNELS)
    ) u_merge (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .lane_stable  (lane_stable),
        .read_channel (s_read_channel),
        .accept       (accept),
        .in_ready     (s_ready),
        .out_valid    (m_valid),
        .out_ready    (m_ready),
        .out_value    (m_count_value)
    );

    // backpressure only when both output entries hold results
    a_ready_implies_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("s_ready low with empty output register");

    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("accepted transaction produced no result");

    a_reset_clears_valid: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid set after reset");

endmodule
